/* hdl/murmur_style_string_hash64_unit_macros.svh */
// Assertion macros shared by the string hash unit.
`ifndef MURMUR_STYLE_STRING_HASH64_UNIT_MACROS_SVH
`define MURMUR_STYLE_STRING_HASH64_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MSH_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mshash_pkg.sv */
// Package: constants, command and status types of the string hash unit.
`timescale 1ns / 1ps
package mshash_pkg;

  localparam logic [63:0] MIX_C1   = 64'h87c37b91114253d5;
  localparam logic [63:0] MIX_C2   = 64'h4cf5ad432745937f;
  localparam logic [63:0] FOLD_ADD = 64'h0000000052dce729;
  localparam logic [63:0] FIN_M1   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FIN_M2   = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] SEED     = 64'd31;

  // Datapath micro-operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_BYTE,
    OP_LD_WORD,
    OP_MUL_LL,
    OP_MUL_HL,
    OP_MUL_LH,
    OP_MUL_END,
    OP_ROT31,
    OP_FOLD,
    OP_MUL5,
    OP_ADDC,
    OP_TAIL_XOR,
    OP_FIN_LOAD,
    OP_SHXOR,
    OP_EMIT
  } mshash_op_t;

  // Phase of the hash sequence; also picks the multiplier constant.
  typedef enum logic [2:0] {
    PH_C1,
    PH_C2,
    PH_M1,
    PH_M2,
    PH_F0
  } mshash_ph_t;

  typedef struct packed {
    mshash_op_t op;
    mshash_ph_t ph;
  } mshash_cmd_t;

  typedef struct packed {
    logic word_full;      // next byte completes a word
    logic tail_nonempty;  // partial word holds bytes
  } mshash_sts_t;

  function automatic logic [63:0] mul_const(input mshash_ph_t ph);
    logic [63:0] k;
    case (ph)
      PH_C1:   k = MIX_C1;
      PH_C2:   k = MIX_C2;
      PH_M1:   k = FIN_M1;
      PH_M2:   k = FIN_M2;
      default: k = MIX_C1;
    endcase
    return k;
  endfunction

endpackage

/* hdl/mshash_dp.sv */
// Datapath: byte gathering, shared 32x32 multiplier, hash and finalizer registers.
`timescale 1ns / 1ps
module mshash_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [7:0]                byte_value,
  input  mshash_pkg::mshash_cmd_t   cmd,
  output mshash_pkg::mshash_sts_t   sts,
  output logic [63:0]               hash_value
);
  import mshash_pkg::*;

  logic [63:0] hash_r, hash_nxt;
  logic [63:0] gather_r, gather_nxt;
  logic [2:0]  slot_r, slot_nxt;
  logic [63:0] total_r, total_nxt;
  logic [63:0] w_r, w_nxt;
  logic [63:0] pp_r;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;
  logic [63:0] kc;
  logic [31:0] mul_a, mul_b;
  logic [63:0] pp_full;
  logic [63:0] fold_x;

  assign kc = mul_const(cmd.ph);

  // Operand halves for the partial products of a 64-bit modular product.
  always_comb begin
    mul_a = w_r[31:0];
    mul_b = kc[31:0];
    case (cmd.op)
      OP_MUL_HL: mul_a = w_r[63:32];
      OP_MUL_LH: mul_b = kc[63:32];
      default: ;
    endcase
  end

  assign pp_full = {32'd0, mul_a} * {32'd0, mul_b};
  assign fold_x  = hash_r ^ w_r;

  always_comb begin
    hash_nxt     = hash_r;
    gather_nxt   = gather_r;
    slot_nxt     = slot_r;
    total_nxt    = total_r;
    w_nxt        = w_r;
    prod_nxt     = prod_r;
    out_hash_nxt = out_hash_r;
    case (cmd.op)
      OP_BYTE: begin
        gather_nxt = gather_r | ({56'd0, byte_value} << {slot_r, 3'b000});
        slot_nxt   = slot_r + 3'd1;
        total_nxt  = total_r + 64'd1;
      end
      OP_LD_WORD:  w_nxt = gather_r;
      OP_MUL_HL:   prod_nxt = pp_r;
      OP_MUL_LH:   prod_nxt = prod_r + {pp_r[31:0], 32'd0};
      OP_MUL_END:  w_nxt = prod_r + {pp_r[31:0], 32'd0};
      OP_ROT31:    w_nxt = {w_r[32:0], w_r[63:33]};
      OP_FOLD:     hash_nxt = {fold_x[36:0], fold_x[63:37]};
      OP_MUL5:     hash_nxt = hash_r + {hash_r[61:0], 2'b00};
      OP_ADDC: begin
        hash_nxt   = hash_r + FOLD_ADD;
        gather_nxt = '0;
      end
      OP_TAIL_XOR: hash_nxt = hash_r ^ w_r;
      OP_FIN_LOAD: w_nxt = hash_r ^ total_r;
      OP_SHXOR:    w_nxt = w_r ^ {33'd0, w_r[63:33]};
      OP_EMIT: begin
        out_hash_nxt = w_r;
        hash_nxt     = SEED;
        gather_nxt   = '0;
        slot_nxt     = '0;
        total_nxt    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r   <= SEED;
      gather_r <= '0;
      slot_r   <= '0;
      total_r  <= '0;
    end else begin
      hash_r   <= hash_nxt;
      gather_r <= gather_nxt;
      slot_r   <= slot_nxt;
      total_r  <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    pp_r       <= pp_full;
    prod_r     <= prod_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign sts.word_full     = (slot_r == 3'd7);
  assign sts.tail_nonempty = (slot_r != 3'd0);
  assign hash_value        = out_hash_r;

endmodule

/* hdl/mshash_ctrl.sv */
// Controller: sequences the datapath micro-operations and owns both handshakes.
`timescale 1ns / 1ps
module mshash_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_byte_present,
  input  logic                      in_last,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  input  mshash_pkg::mshash_sts_t   sts,
  output mshash_pkg::mshash_cmd_t   cmd
);
  import mshash_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LDW,
    S_LL,
    S_HL,
    S_LH,
    S_END,
    S_ROT,
    S_FOLD,
    S_MUL5,
    S_ADDC,
    S_TAIL,
    S_FIN,
    S_SHX,
    S_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  mshash_ph_t phase_r, phase_nxt;
  logic       tail_r, tail_nxt;
  logic       last_r, last_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       emit;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    tail_nxt  = tail_r;
    last_nxt  = last_r;
    emit      = 1'b0;
    cmd.op    = OP_NOP;
    cmd.ph    = phase_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last;
          if (in_byte_present) cmd.op = OP_BYTE;
          if (in_byte_present && sts.word_full) begin
            tail_nxt  = 1'b0;
            state_nxt = S_LDW;
          end else if (in_last) begin
            if (in_byte_present || sts.tail_nonempty) begin
              tail_nxt  = 1'b1;
              state_nxt = S_LDW;
            end else begin
              state_nxt = S_FIN;
            end
          end
        end
      end
      S_LDW: begin
        cmd.op    = OP_LD_WORD;
        phase_nxt = PH_C1;
        state_nxt = S_LL;
      end
      S_LL: begin
        cmd.op    = OP_MUL_LL;
        state_nxt = S_HL;
      end
      S_HL: begin
        cmd.op    = OP_MUL_HL;
        state_nxt = S_LH;
      end
      S_LH: begin
        cmd.op    = OP_MUL_LH;
        state_nxt = S_END;
      end
      S_END: begin
        cmd.op = OP_MUL_END;
        case (phase_r)
          PH_C1:   state_nxt = S_ROT;
          PH_C2:   state_nxt = tail_r ? S_TAIL : S_FOLD;
          default: state_nxt = S_SHX;
        endcase
      end
      S_ROT: begin
        cmd.op    = OP_ROT31;
        phase_nxt = PH_C2;
        state_nxt = S_LL;
      end
      S_FOLD: begin
        cmd.op    = OP_FOLD;
        state_nxt = S_MUL5;
      end
      S_MUL5: begin
        cmd.op    = OP_MUL5;
        state_nxt = S_ADDC;
      end
      S_ADDC: begin
        cmd.op    = OP_ADDC;
        state_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_TAIL: begin
        cmd.op    = OP_TAIL_XOR;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op    = OP_FIN_LOAD;
        phase_nxt = PH_F0;
        state_nxt = S_SHX;
      end
      S_SHX: begin
        cmd.op = OP_SHXOR;
        case (phase_r)
          PH_F0: begin
            phase_nxt = PH_M1;
            state_nxt = S_LL;
          end
          PH_M1: begin
            phase_nxt = PH_M2;
            state_nxt = S_LL;
          end
          default: state_nxt = S_EMIT;
        endcase
      end
      S_EMIT: begin
        // hold until the output register is free or drains this cycle
        if (!out_valid_r || !out_stall) begin
          cmd.op    = OP_EMIT;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = emit | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_C1;
      tail_r      <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      tail_r      <= tail_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hdl/murmur_style_string_hash64_unit.sv */
// Top level: streaming 64-bit string hash, at most one byte per input beat.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_byte_value, in_byte_present, in_last
//   out      output     out_valid / out_stall  out_hash_value
//
// A byte that does not complete a word is taken without a stall; the eighth byte
// of a word is mixed by two 64-bit products on one 32x32 multiplier, plus fold.
// A last beat adds the finalizer, plus a mix of the partial word when one remains.
// Reset is synchronous, active low, and leaves the hash seeded and no result pending.
// A stalled result stays in the output register; the block keeps taking bytes
// and only waits when a second result is ready before the first has left.
`timescale 1ns / 1ps
`include "murmur_style_string_hash64_unit_macros.svh"
module murmur_style_string_hash64_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_byte_present,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value
);
  import mshash_pkg::*;

  mshash_cmd_t cmd;
  mshash_sts_t sts;

  mshash_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_byte_present (in_byte_present),
    .in_last         (in_last),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .sts             (sts),
    .cmd             (cmd)
  );

  mshash_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_value (in_byte_value),
    .cmd        (cmd),
    .sts        (sts),
    .hash_value (out_hash_value)
  );

  `MSH_ASSERT_NEXT(a_last_busy, clk, rst_n, in_valid && !in_stall && in_last, in_stall, "last beat did not start finalization")
  `MSH_ASSERT_NEXT(a_plain_byte_free, clk, rst_n, in_valid && !in_stall && !in_last && !(in_byte_present && sts.word_full), !in_stall, "plain byte beat left the block busy")
  `MSH_ASSERT_NOW(a_emit_slot_free, clk, rst_n, cmd.op == OP_EMIT, !out_valid || !out_stall, "result overwrote a pending beat")
  `MSH_ASSERT_NEXT(a_emit_clears, clk, rst_n, cmd.op == OP_EMIT, !sts.tail_nonempty && out_valid, "state not cleared after result")

endmodule
